FILE: rtl/pmrt_pkg.sv
// package for the pinned module residency table
// types, opcodes and sizing constants; no dependencies
`default_nettype none
package pmrt_pkg;
   localparam int TableDepth   = 16;
   localparam int DefaultLimit = 16;
   localparam int KeyBits      = 32;
   localparam int IdxBits      = 4;
   localparam int CntBits      = 5;

   typedef enum logic [2:0] {
      OP_PIN_REQ  = 3'd0,
      OP_PIN_DONE = 3'd1,
      OP_USE      = 3'd2,
      OP_UNPIN    = 3'd3,
      OP_INVAL    = 3'd4,
      OP_SET_LIM  = 3'd5
   } opcode_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] key;
      logic [31:0] now;
      logic        load_ok;
      logic [31:0] img_size;
      logic [31:0] start_epoch;
      logic [4:0]  new_limit;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic        key_resident;
      logic [4:0]  evicted_count;
      logic [4:0]  resident_count;
      logic [35:0] total_img_size;
      logic [31:0] refusal_count;
      logic [31:0] epoch_tag;
   } rsp_type;

   // one memory word per table entry
   typedef struct packed {
      logic [KeyBits-1:0] key;
      logic               ready;
      logic [31:0]        pinned_time;
      logic [31:0]        last_used;
      logic [31:0]        image_size;
   } entry_type;
endpackage
`default_nettype wire

FILE: rtl/pmrt_entry_ram.sv
// entry store of the residency table: one write port, one registered read port
// depends on pmrt_pkg
`default_nettype none
module pmrt_entry_ram (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [pmrt_pkg::IdxBits-1:0] wr_addr,
   input  wire pmrt_pkg::entry_type    wr_data,
   input  wire logic [pmrt_pkg::IdxBits-1:0] rd_addr,
   output pmrt_pkg::entry_type         rd_data
);
   import pmrt_pkg::*;

   entry_type mem_ff [TableDepth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

FILE: rtl/pinned_module_residency_table_unit.sv
// top level of the pinned module residency table
// depends on pmrt_pkg and pmrt_entry_ram
`default_nettype none
// One item at a time. Each item runs a lookup pass over all 16 entries
// (one entry read per cycle from the entry memory, whose read port is
// registered), then an update, then, if it needs a victim, one more pass
// per victim sought. An item passes through the idle state, the lookup, the
// update, any victim passes and the presentation of the result before the
// next acceptance. A stalled result holds the unit until it is taken. The
// image byte total is a running register, so the result needs no summing
// pass. The entry memory read port sets the pace. Valid bits sit in
// flip-flops, cleared at reset.
module pinned_module_residency_table_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pmrt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pmrt_pkg::rsp_type      rsp_data
);
   import pmrt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FIND, ST_APPLY, ST_SCAN, ST_EVICT, ST_DONE
   } state_type;

   state_type            state_ff;
   req_type              req_ff;
   logic [TableDepth-1:0] valid_ff;
   logic [CntBits-1:0]   count_ff;
   logic [35:0]          total_ff;
   logic [31:0]          epoch_ff;
   logic [CntBits-1:0]   limit_ff;
   logic [31:0]          refuse_ff;
   logic [IdxBits:0]     ptr_ff;       // read address issued, with end bit
   logic                 rd_live_ff;   // read data valid this cycle
   logic [IdxBits-1:0]   rd_idx_ff;
   logic                 hit_ff;
   logic [IdxBits-1:0]   hit_idx_ff;
   entry_type            hit_ent_ff;
   logic                 vic_ff;
   logic                 vic_nu_ff;    // victim is ready and never used
   logic [IdxBits-1:0]   vic_idx_ff;
   entry_type            vic_ent_ff;
   logic                 shrink_ff;    // scan for limit shrink, else admission
   logic [CntBits-1:0]   evict_ff;
   logic                 ok_ff;

   logic                 wr_en;
   logic [IdxBits-1:0]   wr_addr;
   entry_type            wr_data;
   entry_type            rd_data;
   logic [IdxBits-1:0]   free_idx;
   logic [CntBits-1:0]   cap;
   logic                 rd_nu;
   logic                 better;
   logic                 key_res;

   pmrt_entry_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(ptr_ff[IdxBits-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      free_idx = '0;
      for (int i = TableDepth - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = IdxBits'(i);
      end
   end

   assign cap = (limit_ff < CntBits'(TableDepth)) ? limit_ff : CntBits'(TableDepth);
   assign rd_nu = rd_data.ready && (rd_data.last_used == 32'd0);

   // victim preference: never used beats used; then by time, then key
   always_comb begin
      better = 1'b0;
      if (!vic_ff) begin
         better = 1'b1;
      end else if (rd_nu != vic_nu_ff) begin
         better = rd_nu;
      end else if (rd_nu) begin
         better = (rd_data.pinned_time < vic_ent_ff.pinned_time) ||
                  (rd_data.pinned_time == vic_ent_ff.pinned_time &&
                   rd_data.key < vic_ent_ff.key);
      end else begin
         better = (rd_data.last_used < vic_ent_ff.last_used) ||
                  (rd_data.last_used == vic_ent_ff.last_used &&
                   rd_data.key < vic_ent_ff.key);
      end
      // admission only takes never-used entries
      if (!shrink_ff && !rd_nu) better = 1'b0;
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = hit_idx_ff;
      wr_data = hit_ent_ff;
      if (state_ff == ST_APPLY) begin
         case (req_ff.opcode)
            OP_PIN_REQ: begin
               wr_en   = !hit_ff && (count_ff < cap);
               wr_addr = free_idx;
               wr_data.key         = req_ff.key;
               wr_data.ready       = 1'b0;
               wr_data.pinned_time = req_ff.now;
               wr_data.last_used   = 32'd0;
               wr_data.image_size  = 32'd0;
            end
            OP_PIN_DONE: begin
               wr_en = hit_ff && !hit_ent_ff.ready && req_ff.load_ok &&
                       (req_ff.start_epoch == epoch_ff);
               wr_data.ready      = 1'b1;
               wr_data.image_size = req_ff.img_size;
            end
            OP_USE: begin
               wr_en = hit_ff && hit_ent_ff.ready;
               wr_data.last_used = req_ff.now;
            end
            default: wr_en = 1'b0;
         endcase
      end
   end

   always_comb begin
      case (req_ff.opcode)
         OP_PIN_REQ, OP_PIN_DONE: key_res = ok_ff;
         OP_UNPIN, OP_INVAL:      key_res = 1'b0;
         OP_SET_LIM:              key_res = hit_ff && valid_ff[hit_idx_ff];
         default:                 key_res = hit_ff;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         valid_ff  <= '0;
         count_ff  <= '0;
         total_ff  <= '0;
         epoch_ff  <= '0;
         limit_ff  <= CntBits'(DefaultLimit);
         refuse_ff <= '0;
         rsp_valid <= 1'b0;
         ptr_ff    <= '0;
         rd_live_ff <= 1'b0;
      end else begin
         // a read goes out each pass cycle until the pointer reaches the end mark
         rd_live_ff <= ((state_ff == ST_FIND) || (state_ff == ST_SCAN)) && !ptr_ff[IdxBits];
         rd_idx_ff  <= ptr_ff[IdxBits-1:0];
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff     <= req_data;
                  hit_ff     <= 1'b0;
                  vic_ff     <= 1'b0;
                  evict_ff   <= '0;
                  ok_ff      <= 1'b0;
                  ptr_ff     <= '0;
                  state_ff   <= ST_FIND;
               end
            end
            ST_FIND: begin
               if (rd_live_ff && valid_ff[rd_idx_ff] && rd_data.key == req_ff.key) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= rd_idx_ff;
                  hit_ent_ff <= rd_data;
               end
               if (!ptr_ff[IdxBits]) begin
                  ptr_ff <= ptr_ff + (IdxBits+1)'(1);
               end else begin
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               case (req_ff.opcode)
                  OP_PIN_REQ: begin
                     if (hit_ff) begin
                        ok_ff    <= 1'b1;
                        state_ff <= ST_DONE;
                     end else if (count_ff < cap) begin
                        valid_ff[free_idx] <= 1'b1;
                        count_ff <= count_ff + CntBits'(1);
                        ok_ff    <= 1'b1;
                        state_ff <= ST_DONE;
                     end else begin
                        shrink_ff  <= 1'b0;
                        ptr_ff     <= '0;
                        state_ff   <= ST_SCAN;
                     end
                  end
                  OP_PIN_DONE: begin
                     state_ff <= ST_DONE;
                     if (hit_ff) begin
                        if (hit_ent_ff.ready) begin
                           ok_ff <= 1'b1;
                        end else if (wr_en) begin
                           ok_ff    <= 1'b1;
                           total_ff <= total_ff + 36'(req_ff.img_size);
                        end else begin
                           valid_ff[hit_idx_ff] <= 1'b0;
                           count_ff <= count_ff - CntBits'(1);
                        end
                     end
                  end
                  OP_UNPIN, OP_INVAL: begin
                     state_ff <= ST_DONE;
                     if (req_ff.opcode == OP_INVAL) epoch_ff <= epoch_ff + 32'd1;
                     if (hit_ff) begin
                        valid_ff[hit_idx_ff] <= 1'b0;
                        count_ff <= count_ff - CntBits'(1);
                        total_ff <= total_ff - 36'(hit_ent_ff.image_size);
                     end
                  end
                  OP_SET_LIM: begin
                     limit_ff <= req_ff.new_limit;
                     if (count_ff > req_ff.new_limit) begin
                        shrink_ff  <= 1'b1;
                        ptr_ff     <= '0;
                        state_ff   <= ST_SCAN;
                     end else begin
                        state_ff   <= ST_DONE;
                     end
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_SCAN: begin
               if (rd_live_ff && valid_ff[rd_idx_ff] && better) begin
                  vic_ff     <= 1'b1;
                  vic_nu_ff  <= rd_nu;
                  vic_idx_ff <= rd_idx_ff;
                  vic_ent_ff <= rd_data;
               end
               if (!ptr_ff[IdxBits]) begin
                  ptr_ff <= ptr_ff + (IdxBits+1)'(1);
               end else begin
                  state_ff <= ST_EVICT;
               end
            end
            ST_EVICT: begin
               vic_ff <= 1'b0;
               if (!vic_ff) begin
                  // admission found nothing to evict
                  if (refuse_ff != '1) refuse_ff <= refuse_ff + 32'd1;
                  state_ff <= ST_DONE;
               end else begin
                  valid_ff[vic_idx_ff] <= 1'b0;
                  total_ff <= total_ff - 36'(vic_ent_ff.image_size);
                  evict_ff <= evict_ff + CntBits'(1);
                  count_ff <= count_ff - CntBits'(1);
                  if (!shrink_ff) begin
                     // reuse the freed slot: lowest free index after eviction
                     state_ff <= ST_APPLY;
                  end else if (count_ff - CntBits'(1) > req_ff.new_limit) begin
                     ptr_ff   <= '0;
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_DONE: begin
               if (!rsp_valid) begin
                  rsp_valid <= 1'b1;
                  rsp_data.ok             <= ok_ff;
                  rsp_data.key_resident   <= key_res;
                  rsp_data.evicted_count  <= evict_ff;
                  rsp_data.resident_count <= count_ff;
                  rsp_data.total_img_size <= total_ff;
                  rsp_data.refusal_count  <= refuse_ff;
                  rsp_data.epoch_tag      <= epoch_ff;
               end else if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: dv/pinned_module_residency_table_unit_tb.sv
// testbench for pinned_module_residency_table_unit: directed and random items
// checked against a behavioral table model; depends on pmrt_pkg and the rtl
`timescale 1ns / 100ps
`default_nettype none
module pinned_module_residency_table_unit_tb;
   import pmrt_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   pinned_module_residency_table_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // table model state
   bit          tbl_valid [TableDepth];
   bit [31:0]   tbl_key   [TableDepth];
   bit          tbl_ready [TableDepth];
   bit [31:0]   tbl_pinned[TableDepth];
   bit [31:0]   tbl_used  [TableDepth];
   bit [31:0]   tbl_image [TableDepth];
   bit [31:0]   cur_epoch;
   bit [4:0]    cur_limit;
   bit [31:0]   refusals;

   rsp_type     expected_rsps[$];
   int          mismatches;
   int          fail_count;
   bit          hold_off;
   bit [31:0]   key_pool[8];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("pinned_module_residency_table_unit_tb: done, errors");
      $finish;
   end

   function automatic int find_key(bit [31:0] k);
      for (int i = 0; i < TableDepth; i++)
         if (tbl_valid[i] && tbl_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int valid_count();
      int n;
      n = 0;
      for (int i = 0; i < TableDepth; i++) n += tbl_valid[i];
      return n;
   endfunction

   function automatic bit drop_unused_oldest();
      int v;
      v = -1;
      for (int i = 0; i < TableDepth; i++) begin
         if (!tbl_valid[i] || !tbl_ready[i] || tbl_used[i] != 0) continue;
         if (v < 0 || tbl_pinned[i] < tbl_pinned[v] ||
             (tbl_pinned[i] == tbl_pinned[v] && tbl_key[i] < tbl_key[v])) v = i;
      end
      if (v < 0) return 1'b0;
      tbl_valid[v] = 1'b0;
      return 1'b1;
   endfunction

   function automatic void drop_least_recent();
      int v;
      v = -1;
      for (int i = 0; i < TableDepth; i++) begin
         if (!tbl_valid[i]) continue;
         if (v < 0 || tbl_used[i] < tbl_used[v] ||
             (tbl_used[i] == tbl_used[v] && tbl_key[i] < tbl_key[v])) v = i;
      end
      if (v >= 0) tbl_valid[v] = 1'b0;
   endfunction

   function automatic rsp_type apply_table_op(req_type r);
      rsp_type   o;
      int        s;
      int        cap;
      bit        ok;
      bit [4:0]  ev;
      bit [35:0] sum;
      ok = 1'b0;
      ev = '0;
      sum = '0;
      s = find_key(r.key);
      case (r.opcode)
         OP_PIN_REQ: begin
            cap = (cur_limit < TableDepth) ? cur_limit : TableDepth;
            if (s >= 0) ok = 1'b1;
            else begin
               bit room;
               room = 1'b1;
               if (valid_count() >= cap) begin
                  if (!drop_unused_oldest()) begin
                     room = 1'b0;
                     if (refusals != 32'hFFFF_FFFF) refusals++;
                  end else ev++;
               end
               if (room)
                  for (int i = 0; i < TableDepth; i++)
                     if (!tbl_valid[i]) begin
                        tbl_valid[i] = 1'b1; tbl_key[i] = r.key; tbl_ready[i] = 1'b0;
                        tbl_pinned[i] = r.now; tbl_used[i] = '0; tbl_image[i] = '0;
                        ok = 1'b1;
                        break;
                     end
            end
         end
         OP_PIN_DONE: begin
            if (s >= 0) begin
               if (tbl_ready[s]) ok = 1'b1;
               else if (!r.load_ok || r.start_epoch != cur_epoch) tbl_valid[s] = 1'b0;
               else begin
                  tbl_ready[s] = 1'b1; tbl_image[s] = r.img_size; ok = 1'b1;
               end
            end
         end
         OP_USE: if (s >= 0 && tbl_ready[s]) tbl_used[s] = r.now;
         OP_UNPIN: if (s >= 0) tbl_valid[s] = 1'b0;
         OP_INVAL: begin
            cur_epoch++;
            if (s >= 0) tbl_valid[s] = 1'b0;
         end
         OP_SET_LIM: begin
            cur_limit = r.new_limit;
            while (valid_count() > r.new_limit) begin
               if (!drop_unused_oldest()) drop_least_recent();
               ev++;
            end
         end
         default: ;
      endcase
      for (int i = 0; i < TableDepth; i++) if (tbl_valid[i]) sum += tbl_image[i];
      o.ok = ok;
      o.key_resident = (find_key(r.key) >= 0);
      o.evicted_count = ev;
      o.resident_count = valid_count();
      o.total_img_size = sum;
      o.refusal_count = refusals;
      o.epoch_tag = cur_epoch;
      return o;
   endfunction

   // burst/gap pacing on the sender side
   int burst_left;

   task automatic send_item(req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(negedge clock);
      end
      burst_left--;
      req_data  = r;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.insert(expected_rsps.size(), apply_table_op(r));
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic req_type rand_item(bit [2:0] op);
      req_type r;
      r.opcode = op;
      r.key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 9))
         0: r.now = 32'hFFFF_FFFF;
         1: r.now = 32'd0;
         default: r.now = $urandom_range(1, 50);
      endcase
      r.load_ok = ($urandom_range(0, 7) != 0);
      r.img_size = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom();
      r.start_epoch = ($urandom_range(0, 5) == 0) ? $urandom() : cur_epoch;
      r.new_limit = $urandom_range(0, 16);
      return r;
   endfunction

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            fail_count++;
            if (mismatches++ < 10) $display("unexpected item %p", rsp_data);
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (e !== rsp_data) begin
               fail_count++;
               if (mismatches++ < 10) $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   initial begin
      int phase;
      rsp_ready = 1'b0;
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_off) rsp_ready <= 1'b0;
         else if (phase % 128 < 40) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic test_directed();
      req_type r;
      r = '0;
      r.load_ok = 1'b1;
      // pin and complete, extremes of fields
      r.opcode = OP_PIN_REQ; r.key = 32'h0; r.now = 32'd1; send_item(r);
      send_item(r); // already resident
      r.opcode = OP_PIN_DONE; r.img_size = 32'hFFFF_FFFF; r.start_epoch = cur_epoch;
      send_item(r);
      send_item(r); // already ready
      r.opcode = OP_PIN_REQ; r.key = 32'hFFFF_FFFF; r.now = 32'hFFFF_FFFF; send_item(r);
      r.opcode = OP_PIN_DONE; r.load_ok = 1'b0; send_item(r); // load failed
      r.opcode = OP_PIN_DONE; r.key = 32'h1234; send_item(r); // absent key
      r.opcode = OP_PIN_REQ; r.key = 32'h5; send_item(r);
      r.opcode = OP_INVAL; r.key = 32'h99; send_item(r);
      r.opcode = OP_PIN_DONE; r.key = 32'h5; r.load_ok = 1'b1; r.start_epoch = 32'd0;
      send_item(r); // stale epoch
      r.opcode = OP_USE; r.key = 32'h0; r.now = 32'd7; send_item(r);
      r.now = 32'd0; send_item(r); // back to never used
      r.key = 32'h77; send_item(r);
      r.opcode = OP_UNPIN; send_item(r);
      r.key = 32'h0; send_item(r);
      r.opcode = 3'd6; send_item(r);
      r.opcode = 3'd7; send_item(r);
      // small limit: refusal then eviction
      r.opcode = OP_SET_LIM; r.new_limit = 5'd1; send_item(r);
      r.opcode = OP_PIN_REQ; r.key = 32'h10; r.now = 32'd3; send_item(r);
      r.key = 32'h11; send_item(r); // refused, pending entry only
      r.opcode = OP_PIN_DONE; r.key = 32'h10; r.start_epoch = cur_epoch; send_item(r);
      r.opcode = OP_PIN_REQ; r.key = 32'h11; send_item(r); // evicts
      r.opcode = OP_SET_LIM; r.new_limit = 5'd0; send_item(r);
      r.new_limit = 5'd16; send_item(r);
      wait_drained();
   endtask

   task automatic test_random();
      req_type r;
      for (int n = 0; n < 450; n++) begin
         int pick;
         if (n % 60 == 0)
            for (int k = 0; k < 8; k++) key_pool[k] = $urandom_range(0, 3) ? $urandom_range(0, 40)
                                                                        : $urandom();
         pick = $urandom_range(0, 99);
         if (pick < 35) r = rand_item(OP_PIN_REQ);
         else if (pick < 65) r = rand_item(OP_PIN_DONE);
         else if (pick < 80) r = rand_item(OP_USE);
         else if (pick < 87) r = rand_item(OP_UNPIN);
         else if (pick < 91) r = rand_item(OP_INVAL);
         else if (pick < 98) r = rand_item(OP_SET_LIM);
         else r = rand_item(3'($urandom_range(6, 7)));
         send_item(r);
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      req_type r;
      fork
         begin
            hold_off = 1'b1;
            repeat (1500) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int n = 0; n < 30; n++) begin
            r = rand_item(OP_PIN_REQ);
            burst_left = 30;
            send_item(r);
         end
      join
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hold_off = 1'b0;
      burst_left = 0;
      mismatches = 0;
      fail_count = 0;
      for (int i = 0; i < TableDepth; i++) tbl_valid[i] = 1'b0;
      cur_epoch = '0;
      cur_limit = 5'(DefaultLimit);
      refusals = '0;
      for (int k = 0; k < 8; k++) key_pool[k] = k;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      if (fail_count == 0 && expected_rsps.size() == 0)
         $display("pinned_module_residency_table_unit_tb: done, clean");
      else
         $display("pinned_module_residency_table_unit_tb: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
